// ===== rtl/sfdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfdc_pkg
// Shared types and constants for the serial frame deframer and checker.
// ----------------------------------------------------------------------------
package sfdc_pkg;

  localparam int unsigned HEAD_MAX = 8;
  localparam int unsigned HEAD_MIN = 3;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_HEADER_BYTES = 2'd2;
  localparam logic [1:0] REG_LENGTH_POS  = 2'd3;

  typedef enum logic [5:0] {
    PH_HUNT1   = 6'b000001,
    PH_HUNT2   = 6'b000010,
    PH_HEADER  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CHKLO   = 6'b010000,
    PH_CHKHI   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [3:0] header_bytes;
    logic [2:0] length_position;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] frame_byte;
    logic [8:0] byte_index;
    logic       frame_end;
    logic       frame_good;
    logic [7:0] payload_length;
  } result_t;

endpackage

// ===== rtl/sfdc_parser.sv =====
// ----------------------------------------------------------------------------
// sfdc_parser
// Frame parse state, running modulo-256 Fletcher sums and the per-beat result.
// ----------------------------------------------------------------------------
module sfdc_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  sfdc_pkg::cfg_t     cfg,
  input  logic               beat_ok,
  input  logic [7:0]         rx_byte,
  output sfdc_pkg::result_t  res
);

  sfdc_pkg::phase_t phase_r, phase_nxt;
  logic [8:0] pos_r, pos_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] sum_lo_r, sum_lo_nxt;
  logic [7:0] sum_hi_r, sum_hi_nxt;
  logic [7:0] chk_lo_r, chk_lo_nxt;

  logic [3:0] hdr;
  logic [7:0] add_lo;
  logic [7:0] add_hi;
  logic [8:0] pos_inc;
  logic [8:0] pay_end;

  always_comb begin
    if (cfg.header_bytes < 4'(sfdc_pkg::HEAD_MIN)) begin
      hdr = 4'(sfdc_pkg::HEAD_MIN);
    end else if (cfg.header_bytes > 4'(sfdc_pkg::HEAD_MAX)) begin
      hdr = 4'(sfdc_pkg::HEAD_MAX);
    end else begin
      hdr = cfg.header_bytes;
    end
  end

  assign add_lo  = sum_lo_r + rx_byte;
  assign add_hi  = sum_hi_r + add_lo;
  assign pos_inc = pos_r + 9'd1;
  assign pay_end = {5'd0, hdr} + {1'b0, len_r};

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    sum_lo_nxt = sum_lo_r;
    sum_hi_nxt = sum_hi_r;
    chk_lo_nxt = chk_lo_r;
    res        = '0;
    res.frame_byte = rx_byte;
    res.byte_index = pos_r;

    unique case (phase_r)
      sfdc_pkg::PH_HUNT1: begin
        if (rx_byte == cfg.sync_first) begin
          sum_lo_nxt = rx_byte;
          sum_hi_nxt = rx_byte;
          phase_nxt  = sfdc_pkg::PH_HUNT2;
        end
      end
      sfdc_pkg::PH_HUNT2: begin
        if (rx_byte == cfg.sync_second) begin
          sum_lo_nxt = add_lo;
          sum_hi_nxt = add_hi;
          pos_nxt    = 9'd2;
          len_nxt    = '0;
          phase_nxt  = sfdc_pkg::PH_HEADER;
        end else if (rx_byte == cfg.sync_first) begin
          // mismatch byte may itself open a new frame
          sum_lo_nxt = rx_byte;
          sum_hi_nxt = rx_byte;
        end else begin
          phase_nxt = sfdc_pkg::PH_HUNT1;
        end
      end
      sfdc_pkg::PH_HEADER: begin
        res.valid = 1'b1;
        if (pos_r == {6'd0, cfg.length_position}) begin
          len_nxt = rx_byte;
        end
        sum_lo_nxt = add_lo;
        sum_hi_nxt = add_hi;
        pos_nxt    = pos_inc;
        if (pos_inc >= {5'd0, hdr}) begin
          phase_nxt = (len_nxt == 8'd0) ? sfdc_pkg::PH_CHKLO : sfdc_pkg::PH_PAYLOAD;
        end
        res.payload_length = len_nxt;
      end
      sfdc_pkg::PH_PAYLOAD: begin
        res.valid  = 1'b1;
        sum_lo_nxt = add_lo;
        sum_hi_nxt = add_hi;
        pos_nxt    = pos_inc;
        if (pos_inc >= pay_end) begin
          phase_nxt = sfdc_pkg::PH_CHKLO;
        end
        res.payload_length = len_r;
      end
      sfdc_pkg::PH_CHKLO: begin
        res.valid  = 1'b1;
        chk_lo_nxt = rx_byte;
        pos_nxt    = pos_inc;
        phase_nxt  = sfdc_pkg::PH_CHKHI;
        res.payload_length = len_r;
      end
      sfdc_pkg::PH_CHKHI: begin
        res.valid      = 1'b1;
        res.frame_end  = 1'b1;
        res.frame_good = (chk_lo_r == sum_lo_r) && (rx_byte == sum_hi_r);
        phase_nxt      = sfdc_pkg::PH_HUNT1;
        res.payload_length = len_r;
      end
      default: begin
        phase_nxt = sfdc_pkg::PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= sfdc_pkg::PH_HUNT1;
      pos_r    <= '0;
      len_r    <= '0;
      sum_lo_r <= '0;
      sum_hi_r <= '0;
      chk_lo_r <= '0;
    end else if (beat_ok) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
      chk_lo_r <= chk_lo_nxt;
    end
  end

endmodule

// ===== rtl/serial_frame_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// serial_frame_deframer_checker
// Hunts sync-framed records in a byte stream, passes frame bytes through
// and checks the modulo-256 Fletcher checksum trailer.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_stall / in_rx_byte carry one received byte per beat.
//   out_* carry one frame byte per beat with its offset, the latched payload
//   length, and on the last checksum byte frame_end with the verdict.
//   Sync bytes produce no output beat; every later frame byte does.
//   Latency: a result is shown the cycle after its byte is taken.
//   Throughput: one byte per cycle while in_stall is low; the parse logic
//   sits between the parse state registers and a single output register.
//   in_stall rises only while the output register is full and out_stall is
//   high; a stalled output holds its payload.
//   cfg_we / cfg_index / cfg_wdata write the four registers (sync bytes,
//   header length, length offset); writes act from the next byte on.
//   Reset (rst_n low, synchronous) restores register defaults, empties the
//   output register and returns the parser to sync hunting.
// ----------------------------------------------------------------------------
module serial_frame_deframer_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic [8:0] out_byte_index,
  output logic       out_frame_end,
  output logic       out_frame_good,
  output logic [7:0] out_payload_length,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  sfdc_pkg::cfg_t    cfg_r;
  sfdc_pkg::result_t res;
  sfdc_pkg::result_t out_r;
  logic              in_ok;

  assign in_stall = out_r.valid & out_stall;
  assign in_ok    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first      <= '0;
      cfg_r.sync_second     <= '0;
      cfg_r.header_bytes    <= 4'd4;
      cfg_r.length_position <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfdc_pkg::REG_SYNC_FIRST:   cfg_r.sync_first      <= cfg_wdata;
        sfdc_pkg::REG_SYNC_SECOND:  cfg_r.sync_second     <= cfg_wdata;
        sfdc_pkg::REG_HEADER_BYTES: cfg_r.header_bytes    <= cfg_wdata[3:0];
        sfdc_pkg::REG_LENGTH_POS:   cfg_r.length_position <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  sfdc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .beat_ok (in_ok),
    .rx_byte (in_rx_byte),
    .res     (res)
  );

  // output register: refilled on every accepted byte, drained when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (in_ok) begin
      out_r.valid <= res.valid;
    end else if (!out_stall) begin
      out_r.valid <= 1'b0;
    end
    if (in_ok && res.valid) begin
      out_r.frame_byte     <= res.frame_byte;
      out_r.byte_index     <= res.byte_index;
      out_r.frame_end      <= res.frame_end;
      out_r.frame_good     <= res.frame_good;
      out_r.payload_length <= res.payload_length;
    end
  end

  assign out_valid          = out_r.valid;
  assign out_frame_byte     = out_r.frame_byte;
  assign out_byte_index     = out_r.byte_index;
  assign out_frame_end      = out_r.frame_end;
  assign out_frame_good     = out_r.frame_good;
  assign out_payload_length = out_r.payload_length;

endmodule

// ===== verif/sfdc_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfdc_frame_checker
// Watches the byte input, the frame beat output and the register port of the
// deframer. Keeps its own parser and modulo-256 Fletcher sums, queues the beat each
// taken byte should produce, and compares every output beat with the oldest
// one queued.
// ----------------------------------------------------------------------------
module sfdc_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_frame_byte,
  input  logic [8:0] out_byte_index,
  input  logic       out_frame_end,
  input  logic       out_frame_good,
  input  logic [7:0] out_payload_length,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         beats_due,
  output int         beats_checked,
  output int         frames_ok,
  output int         frames_bad
);

  sfdc_pkg::cfg_t    regs;
  sfdc_pkg::phase_t  parse_ph;
  logic [8:0]        pos;
  logic [7:0]        len_latch;
  logic [7:0]        fl_lo;
  logic [7:0]        fl_hi;
  logic [7:0]        chk_lo;
  sfdc_pkg::result_t frame_beats_q[$];
  sfdc_pkg::result_t due;
  int                mismatches;
  int                n_checked;
  int                n_ok;
  int                n_bad;

  initial begin
    mismatches = 0;
    n_checked = 0;
    n_ok = 0;
    n_bad = 0;
  end

  function automatic int unsigned header_len();
    if (regs.header_bytes < sfdc_pkg::HEAD_MIN) return sfdc_pkg::HEAD_MIN;
    if (regs.header_bytes > sfdc_pkg::HEAD_MAX) return sfdc_pkg::HEAD_MAX;
    return 32'(regs.header_bytes);
  endfunction

  function automatic void fletcher_add(input logic [7:0] b);
    fl_lo = fl_lo + b;
    fl_hi = fl_hi + fl_lo;
  endfunction

  // advance the parser by one byte and queue the beat it produces, if any
  function automatic void deframe_byte(input logic [7:0] b);
    int unsigned       hdr;
    sfdc_pkg::result_t r;
    hdr = header_len();
    r = '0;
    r.valid = 1'b1;
    r.frame_byte = b;
    r.byte_index = pos;
    case (parse_ph)
      sfdc_pkg::PH_HUNT1: begin
        if (b == regs.sync_first) begin
          fl_lo = b;
          fl_hi = b;
          parse_ph = sfdc_pkg::PH_HUNT2;
        end
        r.valid = 1'b0;
      end
      sfdc_pkg::PH_HUNT2: begin
        if (b == regs.sync_second) begin
          fletcher_add(b);
          pos = 9'd2;
          len_latch = '0;
          parse_ph = sfdc_pkg::PH_HEADER;
        end else if (b == regs.sync_first) begin
          // failed second sync may itself open a new frame
          fl_lo = b;
          fl_hi = b;
          parse_ph = sfdc_pkg::PH_HUNT2;
        end else begin
          parse_ph = sfdc_pkg::PH_HUNT1;
        end
        r.valid = 1'b0;
      end
      sfdc_pkg::PH_HEADER: begin
        if (pos == 9'(regs.length_position)) len_latch = b;
        fletcher_add(b);
        pos = pos + 9'd1;
        if (32'(pos) >= hdr)
          parse_ph = (len_latch == 8'd0) ? sfdc_pkg::PH_CHKLO : sfdc_pkg::PH_PAYLOAD;
      end
      sfdc_pkg::PH_PAYLOAD: begin
        fletcher_add(b);
        pos = pos + 9'd1;
        if (32'(pos) >= hdr + 32'(len_latch)) parse_ph = sfdc_pkg::PH_CHKLO;
      end
      sfdc_pkg::PH_CHKLO: begin
        chk_lo = b;
        pos = pos + 9'd1;
        parse_ph = sfdc_pkg::PH_CHKHI;
      end
      sfdc_pkg::PH_CHKHI: begin
        r.frame_end = 1'b1;
        r.frame_good = (chk_lo == fl_lo) && (b == fl_hi);
        parse_ph = sfdc_pkg::PH_HUNT1;
      end
      default: begin
        parse_ph = sfdc_pkg::PH_HUNT1;
        r.valid = 1'b0;
      end
    endcase
    r.payload_length = len_latch;
    if (r.valid) frame_beats_q.push_back(r);
  endfunction

  function automatic void check_field(input string fname, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.sync_first = 8'd0;
      regs.sync_second = 8'd0;
      regs.header_bytes = 4'd4;
      regs.length_position = 3'd3;
      parse_ph = sfdc_pkg::PH_HUNT1;
      pos = '0;
      len_latch = '0;
      fl_lo = '0;
      fl_hi = '0;
      chk_lo = '0;
      frame_beats_q.delete();
    end else begin
      // outputs first: a beat leaving now belongs to an earlier byte
      if (out_valid && !out_stall) begin
        if (frame_beats_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected beat, expected none, actual byte %0d index %0d",
                   $time, out_frame_byte, out_byte_index);
        end else begin
          due = frame_beats_q.pop_front();
          check_field("frame_byte", 32'(due.frame_byte), 32'(out_frame_byte));
          check_field("byte_index", 32'(due.byte_index), 32'(out_byte_index));
          check_field("frame_end", 32'(due.frame_end), 32'(out_frame_end));
          check_field("frame_good", 32'(due.frame_good), 32'(out_frame_good));
          check_field("payload_length", 32'(due.payload_length),
                      32'(out_payload_length));
          n_checked++;
          if (due.frame_end) begin
            if (due.frame_good) n_ok++;
            else n_bad++;
          end
        end
      end
      // byte taken at this edge sees the registers from before any write here
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      if (cfg_we) begin
        case (cfg_index)
          sfdc_pkg::REG_SYNC_FIRST:   regs.sync_first = cfg_wdata;
          sfdc_pkg::REG_SYNC_SECOND:  regs.sync_second = cfg_wdata;
          sfdc_pkg::REG_HEADER_BYTES: regs.header_bytes = cfg_wdata[3:0];
          sfdc_pkg::REG_LENGTH_POS:   regs.length_position = cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    beats_due <= frame_beats_q.size();
    beats_checked <= n_checked;
    frames_ok <= n_ok;
    frames_bad <= n_bad;
  end

endmodule

// ===== verif/tb_serial_frame_deframer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_frame_deframer_checker
// Feeds sync-framed byte streams (good, corrupted, truncated and noisy) under
// a series of register settings with random gaps and output stalls; a
// separate frame checker predicts and compares every output beat.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_checker;

  localparam int CYCLE_LIMIT = 100000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_frame_byte;
  logic [8:0] out_byte_index;
  logic       out_frame_end;
  logic       out_frame_good;
  logic [7:0] out_payload_length;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  int fail_count;
  int beats_due;
  int beats_checked;
  int frames_ok;
  int frames_bad;

  int          cycles = 0;
  int          idle_pct = 17;
  int unsigned sent_bytes = 0;
  int          settings_used = 1;

  // stimulus view of the current registers
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;
  int unsigned gen_hdr;
  int unsigned lp_now;

  serial_frame_deframer_checker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_byte     (out_frame_byte),
    .out_byte_index     (out_byte_index),
    .out_frame_end      (out_frame_end),
    .out_frame_good     (out_frame_good),
    .out_payload_length (out_payload_length),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  sfdc_frame_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_byte     (out_frame_byte),
    .out_byte_index     (out_byte_index),
    .out_frame_end      (out_frame_end),
    .out_frame_good     (out_frame_good),
    .out_payload_length (out_payload_length),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .beats_due          (beats_due),
    .beats_checked      (beats_checked),
    .frames_ok          (frames_ok),
    .frames_bad         (frames_bad)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  task automatic send_summed(input logic [7:0] b, inout logic [7:0] lo, inout logic [7:0] hi);
    send_byte(b);
    lo = lo + b;
    hi = hi + lo;
  endtask

  // sync pair, header with length byte, payload, then low/high checksum bytes
  task automatic send_frame(input int unsigned len, input bit corrupt);
    logic [7:0]  lo;
    logic [7:0]  hi;
    int unsigned body;
    lo = '0;
    hi = '0;
    send_summed(sync_a, lo, hi);
    send_summed(sync_b, lo, hi);
    body = (lp_now >= 2 && lp_now < gen_hdr) ? len : 0;
    for (int i = 2; i < gen_hdr; i++)
      send_summed((i == lp_now) ? 8'(len) : 8'($urandom), lo, hi);
    for (int i = 0; i < body; i++)
      send_summed(8'($urandom), lo, hi);
    if (corrupt) begin
      if ($urandom_range(1)) lo = lo ^ 8'($urandom_range(255, 1));
      else hi = hi ^ 8'($urandom_range(255, 1));
    end
    send_byte(lo);
    send_byte(hi);
  endtask

  function automatic int unsigned rand_frame_len();
    return ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(40);
  endfunction

  // sender holds off until every queued beat has drained
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_due != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [7:0] sa, input logic [7:0] sb,
                               input logic [3:0] hb, input logic [2:0] lp);
    cfg_write(sfdc_pkg::REG_SYNC_FIRST, sa);
    cfg_write(sfdc_pkg::REG_SYNC_SECOND, sb);
    // unused upper write bits get random values
    cfg_write(sfdc_pkg::REG_HEADER_BYTES, {4'($urandom), hb});
    cfg_write(sfdc_pkg::REG_LENGTH_POS, {5'($urandom), lp});
    sync_a = sa;
    sync_b = sb;
    gen_hdr = (hb < sfdc_pkg::HEAD_MIN) ? sfdc_pkg::HEAD_MIN :
              (hb > sfdc_pkg::HEAD_MAX) ? sfdc_pkg::HEAD_MAX : 32'(hb);
    lp_now = 32'(lp);
    settings_used++;
  endtask

  task automatic run_traffic(input int unsigned nbytes);
    int unsigned start;
    int unsigned pick;
    start = sent_bytes;
    while (sent_bytes - start < nbytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(rand_frame_len(), $urandom_range(99) < 20);
      end else if (pick < 80) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end else if (pick < 90) begin
        send_byte(sync_a);
        send_byte(8'($urandom));
      end else begin
        send_byte(sync_a);
        send_frame(rand_frame_len(), 1'b0);
      end
    end
    // sometimes leave a frame open so the next settings land mid-frame
    if ($urandom_range(99) < 40) begin
      send_byte(sync_a);
      send_byte(sync_b);
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'd0;
    cfg_we = 1'b0;
    cfg_index = sfdc_pkg::REG_SYNC_FIRST;
    cfg_wdata = 8'd0;
    sync_a = 8'd0;
    sync_b = 8'd0;
    gen_hdr = 4;
    lp_now = 3;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, then sync re-hunt, zero length, bad checksum
    send_frame(1, 1'b0);
    wait_quiet();
    apply_setting(8'hA5, 8'h5A, 4'd4, 3'd3);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_frame(0, 1'b0);
    send_frame(1, 1'b1);
    send_byte(8'hA5);
    send_byte(8'h00);

    for (int ph = 1; ph <= 9; ph++) begin
      wait_quiet();
      idle_pct = (ph == 2 || ph == 3) ? 0 : 17;
      case (ph)
        1: apply_setting(8'h00, 8'hFF, 4'd8, 3'd7);
        2: apply_setting(8'hFF, 8'h00, 4'd3, 3'd2);
        3: apply_setting(8'h3C, 8'h3C, 4'd0, 3'd2);
        4: apply_setting(8'($urandom), 8'($urandom), 4'd15, 3'd5);
        5: apply_setting(8'($urandom), 8'($urandom), 4'd5, 3'd0);
        6: apply_setting(8'($urandom), 8'($urandom), 4'd4, 3'd6);
        7: apply_setting(8'($urandom), 8'($urandom), 4'd9, 3'd1);
        8: apply_setting(8'($urandom), 8'($urandom), 4'd1, 3'd3);
        default: apply_setting(8'($urandom), 8'($urandom), 4'd2, 3'($urandom));
      endcase
      // longest frame: full header and maximum payload length
      if (ph == 1) send_frame(255, 1'b0);
      run_traffic(22);
    end

    wait_quiet();
    $display("covered %0d bytes over %0d register settings, %0d beats compared",
             sent_bytes, settings_used, beats_checked);
    $display("frames closed: %0d with matching checksum, %0d rejected", frames_ok, frames_bad);
    if (fail_count == 0 && beats_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== serial_frame_deframer_checker.f =====
rtl/sfdc_pkg.sv
rtl/sfdc_parser.sv
rtl/serial_frame_deframer_checker.sv
verif/sfdc_frame_checker.sv
verif/tb_serial_frame_deframer_checker.sv
